// ===== rtl/stcg_pkg.sv =====
// Shared constants, codes and types of the scrolling text column generator.
package stcg_pkg;

	localparam int TEXT_DEPTH  = 64;
	localparam int GLYPH_COUNT = 128;
	localparam int GAP_COLUMNS = 1;

	localparam int GLYPH_BYTES = 9;
	localparam int WIDTH_BYTE  = 8;
	localparam int ROWS        = 8;
	localparam int MAX_WIDTH   = 8;

	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);

	localparam int OP_W    = 2;
	localparam int SLOT_W  = 6;
	localparam int GLYPH_W = 7;
	localparam int BIDX_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int ROW_W   = 3;
	localparam int COLOR_W = 24;
	localparam int LEN_W   = 7;
	localparam int COL_W   = 4;
	localparam int CFG_W   = 24;
	localparam int CFG_IW  = 2;

	localparam logic [OP_W-1:0] OP_TEXT = 2'd0;
	localparam logic [OP_W-1:0] OP_FONT = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [CFG_IW-1:0] REG_TEXT_LENGTH      = 2'd0;
	localparam logic [CFG_IW-1:0] REG_TEXT_COLOR       = 2'd1;
	localparam logic [CFG_IW-1:0] REG_BACKGROUND_COLOR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_TRD,
		ST_TXT,
		ST_WID,
		ST_ROWS
	} state_t;

endpackage

// ===== rtl/stcg_if.sv =====
// Valid/ready channel interfaces for commands and pixel results.
interface stcg_cmd_if;
	import stcg_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [SLOT_W-1:0]    slot;
	logic [GLYPH_W-1:0]   glyph;
	logic [BIDX_W-1:0]    byte_index;
	logic [BYTE_W-1:0]    byte_value;

	modport source (output valid, op, slot, glyph, byte_index, byte_value, input ready);
	modport sink   (input valid, op, slot, glyph, byte_index, byte_value, output ready);
endinterface

interface stcg_pix_if;
	import stcg_pkg::*;

	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   row;
	logic               pixel_on;
	logic [COLOR_W-1:0] pixel_color;
	logic               last;

	modport source (output valid, row, pixel_on, pixel_color, last, input ready);
	modport sink   (input valid, row, pixel_on, pixel_color, last, output ready);
endinterface

// ===== rtl/scrolling_text_column_generator.sv =====
// Top level of the scrolling text column generator for an 8-row LED marquee.
//
// The cmd channel carries one transaction per command: op 0 writes a glyph id into
// the text store, op 1 writes one font byte (rows 0..7 or the width byte 8), op 2
// asks for the next column, op 3 does nothing. Each column request yields eight
// transactions on the pix channel, rows 0 through 7, the last one flagged by last.
// The three configuration registers are written through cfg_we/cfg_index/cfg_data. The user
// must write them only while the block is idle; the block itself does not enforce this.
//
// Text and font live in two synchronous RAMs. A column request reads the glyph id from the text
// store, then the width byte through the single font read port; after the width is decoded in
// ST_WID it reads the eight row bytes, one per cycle while the pix receiver does not stall.
// A new column request is taken as the last row read is issued. Load commands are accepted
// while the block is idle or at that same point. A position at or beyond a newly written text
// length first runs a shift-subtract remainder pass (ST_REM, then ST_TRD) before the text read.
//
// When the pix receiver stalls, the font read port stops and the row data waits
// in the RAM output register behind the pix output register; nothing is dropped.
// Reset clears the position, the column offset and the registers to their reset
// values; the RAM contents are undefined until written.
module scrolling_text_column_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	stcg_cmd_if.sink                    cmd,
	stcg_pix_if.source                  pix,
	input  logic                        cfg_we,
	input  logic [stcg_pkg::CFG_IW-1:0] cfg_index,
	input  logic [stcg_pkg::CFG_W-1:0]  cfg_data
);
	import stcg_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic [LEN_W-1:0]   text_length_q;
	logic [COLOR_W-1:0] text_color_q;
	logic [COLOR_W-1:0] background_color_q;

	// Scroll state.
	logic [SLOT_W-1:0] text_position_q;
	logic [COL_W-1:0]  column_offset_q;

	// Per-request working registers.
	logic [SLOT_W-1:0]  pos_q;
	logic [SLOT_W-1:0]  rem_q;
	logic [SLOT_W-1:0]  dv_q;
	logic [2:0]         rem_cnt_q;
	logic [FONT_AW-1:0] base_q;
	logic [ROW_W-1:0]   row_q;
	logic               en_q;
	logic [2:0]         sh_q;

	// Font read stage: metadata that travels with the RAM output register.
	logic             pend_s1;
	logic [ROW_W-1:0] row_s1;
	logic             en_s1;
	logic [2:0]       sh_s1;

	// Output register.
	logic               out_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic               out_on_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	// RAM ports.
	logic               text_we, text_re;
	logic [SLOT_W-1:0]  text_raddr;
	logic [GLYPH_W-1:0] text_rd;
	logic               font_we, font_re;
	logic [FONT_AW-1:0] font_waddr, font_raddr;
	logic [BYTE_W-1:0]  font_rd;

	logic [LEN_W-1:0]   len_eff;
	logic               accept, tick_acc, pos_in_range;
	logic               drain, issue_ok, pix_on;
	logic [LEN_W-1:0]   rem_t;
	logic [SLOT_W-1:0]  rem_step;
	logic [GLYPH_W-1:0] glyph_id;
	logic [FONT_AW-1:0] base_c;

	// Width decode of the current glyph.
	logic [COL_W-1:0]  width_c, period_c, col_c, col_rel, col_nx, sh_full;
	logic              wrap_c;
	logic [LEN_W-1:0]  pos_inc;
	logic [SLOT_W-1:0] pos_nx;

	// A length of zero scrolls one glyph; anything beyond the store is clamped.
	always_comb begin
		if (text_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(text_length_q) > TEXT_DEPTH) begin
			len_eff = LEN_W'(TEXT_DEPTH);
		end else begin
			len_eff = text_length_q;
		end
	end

	// A row waiting in the RAM output register moves on whenever the output
	// register is empty or being taken; a new font read may then replace it.
	assign drain    = pend_s1 && (!out_valid_q || pix.ready);
	assign issue_ok = !pend_s1 || drain;

	assign cmd.ready = (state_q == ST_IDLE) ||
	                   (state_q == ST_ROWS && row_q == ROW_W'(ROWS - 1) && issue_ok);
	assign accept    = cmd.valid && cmd.ready;
	assign tick_acc  = accept && (cmd.op == OP_TICK);

	assign pos_in_range = {1'b0, text_position_q} < len_eff;

	// One step of the shift-subtract remainder of the position by the length.
	assign rem_t    = {rem_q, dv_q[SLOT_W-1]};
	assign rem_step = (rem_t >= len_eff) ? SLOT_W'(rem_t - len_eff) : rem_t[SLOT_W-1:0];

	// Text store.
	assign text_we = accept && (cmd.op == OP_TEXT) && (int'(cmd.slot) < TEXT_DEPTH) &&
	                 (int'(cmd.glyph) < GLYPH_COUNT);
	assign text_re    = (state_q == ST_TRD) || (tick_acc && pos_in_range);
	assign text_raddr = (state_q == ST_TRD) ? pos_q : text_position_q;

	stcg_ram #(.WIDTH(GLYPH_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (cmd.slot),
		.wdata (cmd.glyph),
		.re    (text_re),
		.raddr (text_raddr),
		.rdata (text_rd)
	);

	// Font store: nine bytes per glyph, the width byte last.
	assign font_we = accept && (cmd.op == OP_FONT) && (int'(cmd.glyph) < GLYPH_COUNT) &&
	                 (int'(cmd.byte_index) <= WIDTH_BYTE);
	assign font_waddr = FONT_AW'({cmd.glyph, 3'b000}) + FONT_AW'(cmd.glyph) +
	                    FONT_AW'(cmd.byte_index);

	assign glyph_id = (int'(text_rd) >= GLYPH_COUNT) ? '0 : text_rd;
	assign base_c   = FONT_AW'({glyph_id, 3'b000}) + FONT_AW'(glyph_id);

	assign font_re    = ((state_q == ST_TXT) || (state_q == ST_ROWS)) && issue_ok;
	assign font_raddr = (state_q == ST_TXT) ? base_c + FONT_AW'(WIDTH_BYTE)
	                                         : base_q + FONT_AW'(row_q);

	stcg_ram #(.WIDTH(BYTE_W), .DEPTH(FONT_DEPTH)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (cmd.byte_value),
		.re    (font_re),
		.raddr (font_raddr),
		.rdata (font_rd)
	);

	// Width decode: the column within the glyph period, whether it lies in the
	// lit part, which bit of the row bytes it selects, and the next scroll state.
	always_comb begin
		width_c  = (int'(font_rd) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : font_rd[COL_W-1:0];
		period_c = width_c + COL_W'(GAP_COLUMNS);
		if (period_c == '0) begin
			period_c = COL_W'(1);
		end
		col_c   = (column_offset_q >= period_c) ? period_c - COL_W'(1) : column_offset_q;
		col_rel = col_c - COL_W'(GAP_COLUMNS);
		sh_full = width_c - COL_W'(1) - col_rel;
		col_nx  = col_c + COL_W'(1);
		wrap_c  = col_nx >= period_c;
		pos_inc = {1'b0, pos_q} + LEN_W'(1);
		if (!wrap_c) begin
			pos_nx = pos_q;
		end else if (pos_inc == len_eff) begin
			pos_nx = '0;
		end else begin
			pos_nx = pos_inc[SLOT_W-1:0];
		end
	end

	assign pix_on = en_s1 && font_rd[sh_s1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				state_d = ST_IDLE;
			end
			ST_REM: begin
				if (rem_cnt_q == 3'(SLOT_W - 1)) begin
					state_d = ST_TRD;
				end
			end
			ST_TRD: begin
				state_d = ST_TXT;
			end
			ST_TXT: begin
				if (issue_ok) begin
					state_d = ST_WID;
				end
			end
			ST_WID: begin
				state_d = ST_ROWS;
			end
			ST_ROWS: begin
				if (issue_ok && row_q == ROW_W'(ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (tick_acc) begin
			state_d = pos_in_range ? ST_TXT : ST_REM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			text_length_q      <= LEN_W'(1);
			text_color_q       <= {COLOR_W{1'b1}};
			background_color_q <= '0;
			text_position_q    <= '0;
			column_offset_q    <= '0;
			rem_cnt_q          <= '0;
			row_q              <= '0;
			pend_s1            <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_TEXT_LENGTH:      text_length_q      <= cfg_data[LEN_W-1:0];
					REG_TEXT_COLOR:       text_color_q       <= cfg_data[COLOR_W-1:0];
					REG_BACKGROUND_COLOR: background_color_q <= cfg_data[COLOR_W-1:0];
					default: begin
					end
				endcase
			end

			if (tick_acc) begin
				rem_cnt_q <= '0;
			end else if (state_q == ST_REM) begin
				rem_cnt_q <= rem_cnt_q + 3'd1;
			end

			if (state_q == ST_WID) begin
				text_position_q <= pos_nx;
				column_offset_q <= wrap_c ? '0 : col_nx;
				row_q           <= '0;
			end else if (state_q == ST_ROWS && issue_ok) begin
				row_q <= row_q + ROW_W'(1);
			end

			if (font_re) begin
				pend_s1 <= (state_q == ST_ROWS);
			end else if (drain) begin
				pend_s1 <= 1'b0;
			end

			if (drain) begin
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			pos_q <= text_position_q;
			rem_q <= '0;
			dv_q  <= text_position_q;
		end else if (state_q == ST_REM) begin
			rem_q <= rem_step;
			dv_q  <= dv_q << 1;
			if (rem_cnt_q == 3'(SLOT_W - 1)) begin
				pos_q <= rem_step;
			end
		end

		if (state_q == ST_TXT && issue_ok) begin
			base_q <= base_c;
		end

		if (state_q == ST_WID) begin
			en_q <= (col_c >= COL_W'(GAP_COLUMNS)) && (col_rel < width_c);
			sh_q <= sh_full[2:0];
		end

		if (state_q == ST_ROWS && issue_ok) begin
			row_s1 <= row_q;
			en_s1  <= en_q;
			sh_s1  <= sh_q;
		end

		if (drain) begin
			out_row_q   <= row_s1;
			out_on_q    <= pix_on;
			out_color_q <= pix_on ? text_color_q : background_color_q;
			out_last_q  <= (row_s1 == ROW_W'(ROWS - 1));
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.row         = out_row_q;
	assign pix.pixel_on    = out_on_q;
	assign pix.pixel_color = out_color_q;
	assign pix.last        = out_last_q;

`ifndef SYNTHESIS
	// A row in the RAM output register is never replaced before it moves on.
	a_pend_held: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !drain |=> pend_s1)
		else $error("pending row lost");

	// After the scroll update the position lies within the text length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WID) |=> ({1'b0, text_position_q} < len_eff))
		else $error("text position beyond text length");

	// The remainder pass leaves a position within the text length.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRD) |-> ({1'b0, pos_q} < len_eff))
		else $error("remainder out of range");

	// A column request always starts with a text read or the remainder pass.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (state_q == ST_TXT || state_q == ST_REM))
		else $error("column request not started");
`endif

endmodule

// ===== rtl/stcg_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module stcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
